/* hw/rtl/hrsp_pkg.sv */
// Shared constants and character helpers for the HTTP request stream parser.
package hrsp_pkg;

  localparam logic [1:0] VERDICT_PENDING  = 2'd0;
  localparam logic [1:0] VERDICT_BAD      = 2'd1;
  localparam logic [1:0] VERDICT_COMPLETE = 2'd2;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LC_H  = 8'h68;
  localparam logic [7:0] CHAR_LC_N  = 8'h6e;
  localparam logic [7:0] CHAR_LC_T  = 8'h74;

  localparam logic [3:0] GET_LEN     = 4'd3;
  localparam logic [3:0] VERSION_LEN = 4'd8;
  localparam logic [3:0] SCHEME_LEN  = 4'd7;
  localparam logic [3:0] CONN_LEN    = 4'd11;
  localparam logic [3:0] KEEP_LEN    = 4'd10;
  localparam logic [3:0] CLEN_LEN    = 4'd15;
  localparam logic [3:0] COMMON_LEN  = 4'd3;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? (b | 8'h20) : b;
  endfunction

  function automatic logic is_gap(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB);
  endfunction

  function automatic logic [7:0] get_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "g";
      4'd1:    c = "e";
      4'd2:    c = "t";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] version_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "h";
      4'd1:    c = "t";
      4'd2:    c = "t";
      4'd3:    c = "p";
      4'd4:    c = "/";
      4'd5:    c = "1";
      4'd6:    c = ".";
      4'd7:    c = "1";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] scheme_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "h";
      4'd1:    c = "t";
      4'd2:    c = "t";
      4'd3:    c = "p";
      4'd4:    c = ":";
      4'd5:    c = "/";
      4'd6:    c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] conn_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "n";
      4'd4:    c = "e";
      4'd5:    c = "c";
      4'd6:    c = "t";
      4'd7:    c = "i";
      4'd8:    c = "o";
      4'd9:    c = "n";
      4'd10:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] keep_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "k";
      4'd1:    c = "e";
      4'd2:    c = "e";
      4'd3:    c = "p";
      4'd4:    c = "-";
      4'd5:    c = "a";
      4'd6:    c = "l";
      4'd7:    c = "i";
      4'd8:    c = "v";
      4'd9:    c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] clen_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/http_request_stream_parser.sv */
// Streaming parser for HTTP/1.1 GET requests, one byte per transaction.
//
// Takes a request stream one byte per cycle and returns one result per byte: the byte itself,
// flags for URL path and body bytes, a verdict (pending, bad request, request complete), the
// keep-alive flag and the Content-Length parsed so far. Lines are framed on CR LF; after each
// verdict the parser starts over on a new request line. A byte passes through an input
// register and a result register with one pass of parsing logic between them, so a new byte
// is accepted every cycle and its result is presented from the result register; the only
// limit on throughput is a result held by out_tready, which stalls the input register.
// Content-Length is held in LENGTH_BITS bits and saturates at its all-ones value.
module http_request_stream_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] byte_echo, [9:8] verdict, [10] linger,
                                  // [42:11] body_length, [47:43] zero
  output logic [1:0]  out_tuser   // [0] path_flag, [1] body_flag
);
  import hrsp_pkg::*;

  typedef enum logic [1:0] {
    SEC_REQ,
    SEC_HDR,
    SEC_BODY
  } section_t;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_GAP1,
    PH_PREFIX,
    PH_HOST,
    PH_PATH,
    PH_GAP2,
    PH_VERSION,
    PH_BAD
  } phase_t;

  typedef enum logic [2:0] {
    HC_BOTH,
    HC_CONN,
    HC_CLEN,
    HC_CONN_SKIP,
    HC_CONN_VAL,
    HC_CLEN_SKIP,
    HC_CLEN_VAL,
    HC_OTHER
  } hclass_t;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // input register
  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic             advance;

  // parser state
  section_t               sec_r, sec_nxt;
  phase_t                 phase_r, phase_nxt;
  hclass_t                hc_r, hc_nxt;
  logic [3:0]             mi_r, mi_nxt;
  logic                   after_cr_r, after_cr_nxt;
  logic                   empty_r, empty_nxt;
  logic                   vsm_r, vsm_nxt;
  logic                   keep_r, keep_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;

  // result register
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_path_r, out_body_r, out_linger_r;
  logic [1:0]       out_verdict_r;
  logic [31:0]      out_len_r;

  logic             path_nxt, body_nxt;
  logic [1:0]       verdict_nxt;
  logic [7:0]       lc;
  logic [LENGTH_BITS+3:0]  prod;
  logic [LENGTH_BITS+31:0] len_ext;
  logic [LENGTH_BITS-1:0]  rem_dec;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  assign lc   = to_lower(in_byte_r);
  assign prod = ({4'b0, len_r} << 3) + ({4'b0, len_r} << 1)
              + {{LENGTH_BITS{1'b0}}, in_byte_r[3:0]};
  assign rem_dec = rem_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    sec_nxt      = sec_r;
    phase_nxt    = phase_r;
    hc_nxt       = hc_r;
    mi_nxt       = mi_r;
    after_cr_nxt = after_cr_r;
    empty_nxt    = empty_r;
    vsm_nxt      = vsm_r;
    keep_nxt     = keep_r;
    len_nxt      = len_r;
    rem_nxt      = rem_r;
    path_nxt     = 1'b0;
    body_nxt     = 1'b0;
    verdict_nxt  = VERDICT_PENDING;

    if (sec_r == SEC_BODY) begin
      body_nxt = 1'b1;
      rem_nxt  = (rem_r != '0) ? rem_dec : rem_r;
      if (rem_nxt == '0) begin
        verdict_nxt = VERDICT_COMPLETE;
      end
    end else if (after_cr_r) begin
      after_cr_nxt = 1'b0;
      if (in_byte_r != CHAR_LF) begin
        verdict_nxt = VERDICT_BAD;
      end else if (sec_r == SEC_HDR) begin
        if (empty_r) begin
          if (len_r == '0) begin
            verdict_nxt = VERDICT_COMPLETE;
          end else begin
            sec_nxt = SEC_BODY;
            rem_nxt = len_r;
          end
        end else begin
          if (hc_r == HC_CONN_VAL && vsm_r && mi_r == KEEP_LEN) begin
            keep_nxt = 1'b1;
          end
          hc_nxt    = HC_BOTH;
          mi_nxt    = '0;
          vsm_nxt   = 1'b0;
          empty_nxt = 1'b1;
        end
      end else if (phase_r == PH_VERSION && mi_r == VERSION_LEN) begin
        sec_nxt   = SEC_HDR;
        phase_nxt = PH_METHOD;
        hc_nxt    = HC_BOTH;
        mi_nxt    = '0;
        empty_nxt = 1'b1;
      end else begin
        verdict_nxt = VERDICT_BAD;
      end
    end else if (in_byte_r == CHAR_CR) begin
      after_cr_nxt = 1'b1;
    end else if (in_byte_r == CHAR_LF) begin
      verdict_nxt = VERDICT_BAD;
    end else if (sec_r == SEC_HDR) begin
      empty_nxt = 1'b0;
      unique case (hc_r) inside
        HC_BOTH: begin
          if (mi_r < COMMON_LEN) begin
            if (lc == conn_char(mi_r)) begin
              mi_nxt = mi_r + 4'd1;
            end else begin
              hc_nxt = HC_OTHER;
            end
          end else if (lc == CHAR_LC_N) begin
            hc_nxt = HC_CONN;
            mi_nxt = 4'd4;
          end else if (lc == CHAR_LC_T) begin
            hc_nxt = HC_CLEN;
            mi_nxt = 4'd4;
          end else begin
            hc_nxt = HC_OTHER;
          end
        end
        HC_CONN: begin
          if (mi_r < CONN_LEN && lc == conn_char(mi_r)) begin
            mi_nxt = mi_r + 4'd1;
            if (mi_nxt == CONN_LEN) begin
              hc_nxt  = HC_CONN_SKIP;
              mi_nxt  = '0;
              vsm_nxt = 1'b1;
            end
          end else begin
            hc_nxt = HC_OTHER;
          end
        end
        HC_CLEN: begin
          if (mi_r < CLEN_LEN && lc == clen_char(mi_r)) begin
            mi_nxt = mi_r + 4'd1;
            if (mi_nxt == CLEN_LEN) begin
              hc_nxt  = HC_CLEN_SKIP;
              mi_nxt  = '0;
              len_nxt = '0;
            end
          end else begin
            hc_nxt = HC_OTHER;
          end
        end
        HC_CONN_SKIP, HC_CONN_VAL: begin
          if (hc_r == HC_CONN_SKIP && is_gap(in_byte_r)) begin
            hc_nxt = HC_CONN_SKIP;
          end else begin
            hc_nxt = HC_CONN_VAL;
            if (vsm_r && mi_r < KEEP_LEN && lc == keep_char(mi_r)) begin
              mi_nxt = mi_r + 4'd1;
            end else begin
              vsm_nxt = 1'b0;
            end
          end
        end
        HC_CLEN_SKIP, HC_CLEN_VAL: begin
          if (hc_r == HC_CLEN_SKIP && is_gap(in_byte_r)) begin
            hc_nxt = HC_CLEN_SKIP;
          end else if (in_byte_r >= CHAR_ZERO && in_byte_r <= CHAR_NINE) begin
            hc_nxt  = HC_CLEN_VAL;
            len_nxt = (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? LEN_MAX
                                                                 : prod[LENGTH_BITS-1:0];
          end else begin
            hc_nxt = HC_OTHER;
          end
        end
        default: hc_nxt = hc_r;
      endcase
    end else begin
      empty_nxt = 1'b0;
      unique case (phase_r)
        PH_METHOD: begin
          if (is_gap(in_byte_r)) begin
            phase_nxt = (mi_r == GET_LEN) ? PH_GAP1 : PH_BAD;
          end else if (mi_r < GET_LEN && lc == get_char(mi_r)) begin
            mi_nxt = mi_r + 4'd1;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_GAP1: begin
          if (in_byte_r == CHAR_SLASH) begin
            phase_nxt = PH_PATH;
            path_nxt  = 1'b1;
          end else if (lc == CHAR_LC_H) begin
            phase_nxt = PH_PREFIX;
            mi_nxt    = 4'd1;
          end else if (!is_gap(in_byte_r)) begin
            phase_nxt = PH_BAD;
          end
        end
        PH_PREFIX: begin
          if (mi_r < SCHEME_LEN && lc == scheme_char(mi_r)) begin
            mi_nxt = mi_r + 4'd1;
            if (mi_nxt == SCHEME_LEN) begin
              phase_nxt = PH_HOST;
            end
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_HOST: begin
          if (in_byte_r == CHAR_SLASH) begin
            phase_nxt = PH_PATH;
            path_nxt  = 1'b1;
          end else if (is_gap(in_byte_r)) begin
            phase_nxt = PH_BAD;
          end
        end
        PH_PATH: begin
          if (is_gap(in_byte_r)) begin
            phase_nxt = PH_GAP2;
          end else begin
            path_nxt = 1'b1;
          end
        end
        PH_GAP2: begin
          if (!is_gap(in_byte_r)) begin
            if (lc == version_char(4'd0)) begin
              phase_nxt = PH_VERSION;
              mi_nxt    = 4'd1;
            end else begin
              phase_nxt = PH_BAD;
            end
          end
        end
        PH_VERSION: begin
          if (mi_r < VERSION_LEN && lc == version_char(mi_r)) begin
            mi_nxt = mi_r + 4'd1;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        default: phase_nxt = PH_BAD;
      endcase
    end
  end

  assign len_ext = {32'b0, len_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sec_r       <= SEC_REQ;
      phase_r     <= PH_METHOD;
      hc_r        <= HC_BOTH;
      mi_r        <= '0;
      after_cr_r  <= 1'b0;
      empty_r     <= 1'b1;
      vsm_r       <= 1'b0;
      keep_r      <= 1'b0;
      len_r       <= '0;
      rem_r       <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (advance && in_valid_r) begin
        if (verdict_nxt != VERDICT_PENDING) begin
          sec_r      <= SEC_REQ;
          phase_r    <= PH_METHOD;
          hc_r       <= HC_BOTH;
          mi_r       <= '0;
          after_cr_r <= 1'b0;
          empty_r    <= 1'b1;
          vsm_r      <= 1'b0;
          keep_r     <= 1'b0;
          len_r      <= '0;
          rem_r      <= '0;
        end else begin
          sec_r      <= sec_nxt;
          phase_r    <= phase_nxt;
          hc_r       <= hc_nxt;
          mi_r       <= mi_nxt;
          after_cr_r <= after_cr_nxt;
          empty_r    <= empty_nxt;
          vsm_r      <= vsm_nxt;
          keep_r     <= keep_nxt;
          len_r      <= len_nxt;
          rem_r      <= rem_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (advance && in_valid_r) begin
      out_byte_r    <= in_byte_r;
      out_path_r    <= path_nxt;
      out_body_r    <= body_nxt;
      out_verdict_r <= verdict_nxt;
      out_linger_r  <= keep_nxt;
      out_len_r     <= len_ext[31:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_len_r, out_linger_r, out_verdict_r, out_byte_r};
  assign out_tuser  = {out_body_r, out_path_r};

  a_body_remaining_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r == SEC_BODY |-> rem_r != '0)
    else $error("body section entered with nothing left to receive");

  a_no_cr_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r == SEC_BODY |-> !after_cr_r)
    else $error("pending CR carried into the body");

  a_path_body_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("byte flagged as both path and body");

  a_body_never_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[9:8] != VERDICT_BAD)
    else $error("bad request reported on a body byte");

endmodule
